// File: rtl/flps_pkg.sv
package flps_pkg;

  // Result offsets are always reported in eight bits.
  localparam int OFS_W           = 8;
  localparam int CH_W            = 8;
  localparam int MAX_LEN_DEFAULT = 255;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_POINT_CHAR = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEX_MODE   = 1'd1;

  localparam logic [CH_W-1:0] POINT_CHAR_RESET = 8'h2E;

  // Character codes.
  localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CH_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CH_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CH_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CH_W-1:0] CH_UC_A  = 8'h41;
  localparam logic [CH_W-1:0] CH_UC_F  = 8'h46;
  localparam logic [CH_W-1:0] CH_LC_A  = 8'h61;
  localparam logic [CH_W-1:0] CH_LC_F  = 8'h66;
  localparam logic [CH_W-1:0] CH_UC_E  = 8'h45;
  localparam logic [CH_W-1:0] CH_LC_E  = 8'h65;
  localparam logic [CH_W-1:0] CH_UC_P  = 8'h50;
  localparam logic [CH_W-1:0] CH_LC_P  = 8'h70;
  localparam logic [CH_W-1:0] CH_UC_X  = 8'h58;
  localparam logic [CH_W-1:0] CH_LC_X  = 8'h78;

  // State of one digit-run tracker.
  typedef enum logic [8:0] {
    TS_OFF   = 9'b0_0000_0001,
    TS_FRESH = 9'b0_0000_0010,
    TS_LEAD  = 9'b0_0000_0100,
    TS_SIGN  = 9'b0_0000_1000,
    TS_ZERO  = 9'b0_0001_0000,
    TS_ZX    = 9'b0_0010_0000,
    TS_DIG   = 9'b0_0100_0000,
    TS_NODIG = 9'b0_1000_0000,
    TS_DONE  = 9'b1_0000_0000
  } trk_state_t;

  // Per-character control from the top level to each radix lane.
  typedef struct packed {
    logic step;    // a character is taken into the scan
    logic first;   // that character sits at offset zero
    logic finish;  // the string ends with this transfer
  } lane_ctl_t;

  function automatic logic is_blank(logic [CH_W-1:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic logic is_sign(logic [CH_W-1:0] c);
    return (c == CH_PLUS) || (c == CH_MINUS);
  endfunction

  function automatic logic is_digit(logic [CH_W-1:0] c, logic hex);
    logic dec;
    dec = (c >= CH_ZERO) && (c <= CH_NINE);
    return dec || (hex && (((c >= CH_LC_A) && (c <= CH_LC_F)) ||
                           ((c >= CH_UC_A) && (c <= CH_UC_F))));
  endfunction

  function automatic logic is_mark(logic [CH_W-1:0] c, logic hex);
    return hex ? ((c == CH_LC_P) || (c == CH_UC_P)) : ((c == CH_LC_E) || (c == CH_UC_E));
  endfunction

  function automatic logic is_x(logic [CH_W-1:0] c);
    return (c == CH_LC_X) || (c == CH_UC_X);
  endfunction

endpackage

// File: rtl/float_literal_part_scanner_core.sv
// Floating-point literal part scanner.
//
// The characters of one numeric string arrive on the slave stream, one per
// transfer, with tlast on the final character. On that transfer the block
// works out where the integer part, the fraction and the exponent end, and
// one result leaves on the master stream: three eight-bit offsets in tdata
// and the too-long flag in tuser. Other characters produce no result.
// The result is valid in the cycle after the last character's transfer.
// One character is taken every cycle; the whole scan is a set of small
// per-character run trackers, for base ten and base sixteen side by side,
// so the point character and the mode are applied only at the end.
// The result register frees up as it is read, so input keeps flowing while
// a result is taken; only a result that is held by a stalled receiver stops
// input. Characters beyond MAX_LEN are dropped and flagged.
// Reset clears the string count, the result valid and the configuration
// (point character 0x2E, base ten).
module float_literal_part_scanner_core
  import flps_pkg::*;
#(
  parameter int MAX_LEN = MAX_LEN_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wen,
  input  logic [CFG_IDX_W-1:0] cfg_addr,
  input  logic [CH_W-1:0]      cfg_wdata,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [CH_W-1:0]      s_tdata,   // [7:0] ch
  input  logic                 s_tlast,   // last
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [3*OFS_W-1:0]   m_tdata,   // [7:0] int_end, [15:8] frac_end, [23:16] exp_end
  output logic                 m_tuser    // too_long
);

  localparam int PW = $clog2(MAX_LEN + 1);

  logic [CH_W-1:0] point_char;
  logic            hex_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      point_char <= POINT_CHAR_RESET;
      hex_mode   <= 1'b0;
    end else if (cfg_wen) begin
      case (cfg_addr)
        REG_POINT_CHAR: point_char <= cfg_wdata;
        REG_HEX_MODE:   hex_mode   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Input side: a transfer may land whenever the result register is free or
  // is being emptied in the same cycle.
  logic          accept, kept;
  logic [PW-1:0] count;
  logic          dropped;
  logic [PW-1:0] len;
  logic [CH_W-1:0] first_ch, prev_ch, first_cur, latest_ch;
  lane_ctl_t     ctl;

  assign s_tready  = !m_tvalid || m_tready;
  assign accept    = s_tvalid && s_tready;
  assign kept      = accept && (count != PW'(MAX_LEN));
  assign ctl.step  = kept;
  assign ctl.first = kept && (count == '0);
  assign ctl.finish = accept && s_tlast;
  assign len       = count + PW'(kept);
  assign first_cur = ctl.first ? s_tdata : first_ch;
  assign latest_ch = kept ? s_tdata : prev_ch;

  always_ff @(posedge clk) begin
    if (rst || ctl.finish) begin
      count   <= '0;
      dropped <= 1'b0;
    end else if (kept) begin
      count <= count + PW'(1);
    end else if (accept) begin
      dropped <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (kept) begin
      prev_ch <= s_tdata;
    end
    if (ctl.first) begin
      first_ch <= s_tdata;
    end
  end

  // Both radix lanes follow every string; the mode picks one at the end.
  logic [PW-1:0] dec_int, dec_frac, dec_exp, hex_int, hex_frac, hex_exp;

  flps_lane #(.MAX_LEN(MAX_LEN)) u_dec_lane (
    .clk        (clk),
    .rst        (rst),
    .hex        (1'b0),
    .ctl        (ctl),
    .ch         (s_tdata),
    .prev_ch    (prev_ch),
    .latest_ch  (latest_ch),
    .first_ch   (first_cur),
    .point_char (point_char),
    .pos        (count),
    .len        (len),
    .int_end    (dec_int),
    .frac_end   (dec_frac),
    .exp_end    (dec_exp)
  );

  flps_lane #(.MAX_LEN(MAX_LEN)) u_hex_lane (
    .clk        (clk),
    .rst        (rst),
    .hex        (1'b1),
    .ctl        (ctl),
    .ch         (s_tdata),
    .prev_ch    (prev_ch),
    .latest_ch  (latest_ch),
    .first_ch   (first_cur),
    .point_char (point_char),
    .pos        (count),
    .len        (len),
    .int_end    (hex_int),
    .frac_end   (hex_frac),
    .exp_end    (hex_exp)
  );

  logic [PW-1:0] sel_int, sel_frac, sel_exp;

  assign sel_int  = hex_mode ? hex_int  : dec_int;
  assign sel_frac = hex_mode ? hex_frac : dec_frac;
  assign sel_exp  = hex_mode ? hex_exp  : dec_exp;

  // Result register; it is loaded on the last character of each string.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ctl.finish) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.finish) begin
      m_tdata <= {OFS_W'(sel_exp), OFS_W'(sel_frac), OFS_W'(sel_int)};
      m_tuser <= dropped || !kept;
    end
  end

endmodule

// File: rtl/flps_lane.sv
module flps_lane
  import flps_pkg::*;
#(
  parameter int MAX_LEN = MAX_LEN_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                hex,
  input  lane_ctl_t                           ctl,
  input  logic [CH_W-1:0]                     ch,
  input  logic [CH_W-1:0]                     prev_ch,
  input  logic [CH_W-1:0]                     latest_ch,
  input  logic [CH_W-1:0]                     first_ch,
  input  logic [CH_W-1:0]                     point_char,
  input  logic [$clog2(MAX_LEN+1)-1:0]        pos,
  input  logic [$clog2(MAX_LEN+1)-1:0]        len,
  output logic [$clog2(MAX_LEN+1)-1:0]        int_end,
  output logic [$clog2(MAX_LEN+1)-1:0]        frac_end,
  output logic [$clog2(MAX_LEN+1)-1:0]        exp_end
);

  localparam int PW = $clog2(MAX_LEN + 1);

  typedef struct packed {
    trk_state_t    st;
    logic [PW-1:0] ofs;
  } trk_t;

  typedef struct packed {
    trk_t t;
    logic done;  // run ended on this character
    logic zx;    // run ended one character back, at an "x" of a failed prefix
    logic xm;    // the character that stops the run is an exponent mark
  } step_t;

  typedef struct packed {
    logic          dig;
    logic [PW-1:0] ofs;
  } fin_t;

  localparam trk_t TRK_OFF   = '{st: TS_OFF, ofs: '0};
  localparam trk_t TRK_FRESH = '{st: TS_FRESH, ofs: '0};

  // One character of an integer-conversion run: blanks, sign, hex prefix, digits.
  function automatic step_t trk_step(trk_t t, logic [CH_W-1:0] c, logic rad16,
                                     logic mhex, logic [PW-1:0] p);
    step_t s;
    s.t    = t;
    s.done = 1'b0;
    s.zx   = 1'b0;
    s.xm   = 1'b0;
    case (t.st)
      TS_FRESH, TS_LEAD, TS_SIGN: begin
        if ((t.st != TS_SIGN) && is_blank(c)) begin
          s.t.st = TS_LEAD;
        end else if ((t.st != TS_SIGN) && is_sign(c)) begin
          s.t.st = TS_SIGN;
        end else if (rad16 && (c == CH_ZERO)) begin
          s.t.st = TS_ZERO;
        end else if (is_digit(c, rad16)) begin
          s.t.st = TS_DIG;
        end else begin
          s.t.st = TS_NODIG;
          s.xm   = (t.st == TS_FRESH) && is_mark(c, mhex);
        end
      end
      TS_ZERO: begin
        if (is_x(c)) begin
          s.t.st = TS_ZX;
        end else if (is_digit(c, 1'b1)) begin
          s.t.st = TS_DIG;
        end else begin
          s.t.st  = TS_DONE;
          s.t.ofs = p;
          s.done  = 1'b1;
          s.xm    = is_mark(c, mhex);
        end
      end
      TS_ZX: begin
        if (is_digit(c, 1'b1)) begin
          s.t.st = TS_DIG;
        end else begin
          s.t.st  = TS_DONE;
          s.t.ofs = p - PW'(1);
          s.zx    = 1'b1;
        end
      end
      TS_DIG: begin
        if (!is_digit(c, rad16)) begin
          s.t.st  = TS_DONE;
          s.t.ofs = p;
          s.done  = 1'b1;
          s.xm    = is_mark(c, mhex);
        end
      end
      default: ;
    endcase
    return s;
  endfunction

  // Outcome of a run once the string has ended.
  function automatic fin_t trk_fin(trk_t t, logic [PW-1:0] n);
    fin_t f;
    f.dig = 1'b1;
    f.ofs = n;
    case (t.st)
      TS_DONE:         f.ofs = t.ofs;
      TS_DIG, TS_ZERO: f.ofs = n;
      TS_ZX:           f.ofs = n - PW'(1);
      default: begin
        f.dig = 1'b0;
        f.ofs = '0;
      end
    endcase
    return f;
  endfunction

  // Integer run from offset zero, runs from offset one for the no-integer case,
  // and runs that start behind the integer run once it has ended.
  trk_t int_run, frac1_run, exp1_run, exp_f1_run, frac_run, exp_fr_run, exp_np_run;
  trk_t int_run_next, frac1_run_next, exp1_run_next, exp_f1_run_next;
  trk_t frac_run_next, exp_fr_run_next, exp_np_run_next;
  logic mark_int, mark_f1, mark_fr;
  logic mark_int_next, mark_f1_next, mark_fr_next;
  logic [CH_W-1:0] point_cand, point_cand_next;

  step_t s_int, s_f1, s_x1, s_xf1, s_fr, s_xfr, s_xnp;
  trk_t  fr_src;

  always_comb begin
    s_int  = trk_step(int_run, ch, hex, hex, pos);
    fr_src = s_int.zx ? TRK_FRESH : frac_run;
    s_fr   = trk_step(fr_src, ch, hex, hex, pos);
    s_f1   = trk_step(frac1_run, ch, hex, hex, pos);
    s_x1   = trk_step(exp1_run, ch, 1'b0, hex, pos);
    s_xf1  = trk_step(exp_f1_run, ch, 1'b0, hex, pos);
    s_xfr  = trk_step(exp_fr_run, ch, 1'b0, hex, pos);
    s_xnp  = trk_step(exp_np_run, ch, 1'b0, hex, pos);

    int_run_next    = int_run;
    frac1_run_next  = frac1_run;
    exp1_run_next   = exp1_run;
    exp_f1_run_next = exp_f1_run;
    frac_run_next   = frac_run;
    exp_fr_run_next = exp_fr_run;
    exp_np_run_next = exp_np_run;
    mark_int_next   = mark_int;
    mark_f1_next    = mark_f1;
    mark_fr_next    = mark_fr;
    point_cand_next = point_cand;

    if (ctl.step) begin
      int_run_next    = s_int.t;
      // A failed hex prefix ends the integer run one character back, so the
      // fraction run already takes the present character.
      frac_run_next   = s_int.done ? TRK_FRESH : s_fr.t;
      exp_np_run_next = s_int.xm ? TRK_FRESH : s_xnp.t;
      frac1_run_next  = ctl.first ? TRK_FRESH : s_f1.t;
      exp1_run_next   = ctl.first ? TRK_FRESH : s_x1.t;
      exp_f1_run_next = s_f1.xm ? TRK_FRESH : s_xf1.t;
      exp_fr_run_next = s_fr.xm ? TRK_FRESH : s_xfr.t;
      mark_int_next   = mark_int | s_int.xm;
      mark_f1_next    = mark_f1 | s_f1.xm;
      mark_fr_next    = mark_fr | s_fr.xm;
      if (s_int.done) begin
        point_cand_next = ch;
      end else if (s_int.zx) begin
        point_cand_next = prev_ch;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.finish) begin
      int_run    <= TRK_FRESH;
      frac1_run  <= TRK_OFF;
      exp1_run   <= TRK_OFF;
      exp_f1_run <= TRK_OFF;
      frac_run   <= TRK_OFF;
      exp_fr_run <= TRK_OFF;
      exp_np_run <= TRK_OFF;
      mark_int   <= 1'b0;
      mark_f1    <= 1'b0;
      mark_fr    <= 1'b0;
    end else begin
      int_run    <= int_run_next;
      frac1_run  <= frac1_run_next;
      exp1_run   <= exp1_run_next;
      exp_f1_run <= exp_f1_run_next;
      frac_run   <= frac_run_next;
      exp_fr_run <= exp_fr_run_next;
      exp_np_run <= exp_np_run_next;
      mark_int   <= mark_int_next;
      mark_f1    <= mark_f1_next;
      mark_fr    <= mark_fr_next;
    end
  end

  always_ff @(posedge clk) begin
    point_cand <= point_cand_next;
  end

  // Pick the branch that the full string selects.
  fin_t f_int, f_frac, f_exp;
  logic has_cand;
  logic [CH_W-1:0] cand;

  always_comb begin
    f_int    = trk_fin(int_run_next, len);
    f_frac   = trk_fin(frac1_run_next, len);
    f_exp    = trk_fin(exp1_run_next, len);
    has_cand = (int_run_next.st == TS_DONE) || (int_run_next.st == TS_ZX);
    cand     = (int_run_next.st == TS_ZX) ? latest_ch : point_cand_next;
    int_end  = '0;
    frac_end = '0;
    exp_end  = '0;
    if (!f_int.dig) begin
      if (first_ch == point_char) begin
        // A point with no digits on either side gives all offsets as zero.
        f_frac = trk_fin(frac1_run_next, len);
        f_exp  = trk_fin(exp_f1_run_next, len);
        if (f_frac.dig) begin
          frac_end = f_frac.ofs;
          exp_end  = (mark_f1_next && f_exp.dig) ? f_exp.ofs : f_frac.ofs;
        end
      end else begin
        f_exp   = trk_fin(exp1_run_next, len);
        exp_end = (is_mark(first_ch, hex) && f_exp.dig) ? f_exp.ofs : '0;
      end
    end else begin
      int_end = f_int.ofs;
      if (has_cand && (cand == point_char)) begin
        f_frac   = trk_fin(frac_run_next, len);
        f_exp    = trk_fin(exp_fr_run_next, len);
        frac_end = f_frac.dig ? f_frac.ofs : (f_int.ofs + PW'(1));
        exp_end  = (mark_fr_next && f_exp.dig) ? f_exp.ofs : frac_end;
      end else begin
        f_exp    = trk_fin(exp_np_run_next, len);
        frac_end = f_int.ofs;
        exp_end  = (mark_int_next && f_exp.dig) ? f_exp.ofs : f_int.ofs;
      end
    end
  end

endmodule
